// ----- design/bpa_pkg.sv -----
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared constants and types for the buddy page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int MAX_PAGES = 1024;
  localparam int LVL       = $clog2(MAX_PAGES);
  localparam int NODES     = 2 * MAX_PAGES;
  localparam int IDX_W     = LVL + 1;      // tree node index
  localparam int VAL_W     = LVL + 1;      // node size mask
  localparam int K_W       = $clog2(LVL + 1);

  localparam int CNT_W  = 11;              // page_count / free_count / usable_pages
  localparam int PAGE_W = 10;              // page_index / block_start

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [IDX_W-1:0] ROOT_NODE = IDX_W'(1);

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    logic [VAL_W-1:0] wdata;
  } bpa_mem_req_t;

endpackage

// ----- design/bpa_ifs.sv -----
// ----------------------------------------------------------------------------
// bpa_ifs
// Valid/ready channels of the buddy page allocator.
// ----------------------------------------------------------------------------
interface bpa_req_if import bpa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              command;
  logic [CNT_W-1:0]  page_count;
  logic [PAGE_W-1:0] page_index;
  modport source (output valid, command, page_count, page_index, input ready);
  modport sink   (input valid, command, page_count, page_index, output ready);
endinterface

interface bpa_rsp_if import bpa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              ok;
  logic [PAGE_W-1:0] block_start;
  logic [CNT_W-1:0]  free_count;
  modport source (output valid, ok, block_start, free_count, input ready);
  modport sink   (input valid, ok, block_start, free_count, output ready);
endinterface

interface bpa_cfg_if import bpa_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] usable_pages;
  modport source (output valid, usable_pages, input ready);
  modport sink   (input valid, usable_pages, output ready);
endinterface

// ----- design/buddy_page_allocator.sv -----
// ----------------------------------------------------------------------------
// buddy_page_allocator
// Binary buddy tree allocator, one tree memory under a small sequencer.
// ----------------------------------------------------------------------------
// Alloc: a walk down the tree, splitting or reading both children per level,
//   then a walk back up; free: a node write, then a walk up to the root.
// One item at a time; the next item is taken the cycle after the result is
//   loaded; each tree level costs a read/modify/write on the single port.
// Reset or a usable_pages write: a clearing pass over every node, then the
//   build walk; no item is accepted meanwhile.
module buddy_page_allocator import bpa_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  bpa_cfg_if.sink   cfg,
  bpa_req_if.sink   req,
  bpa_rsp_if.source rsp
);

  typedef enum logic [3:0] {
    S_CLR, S_BROOT, S_BSTEP, S_BW2, S_IDLE,
    S_A_RD, S_A_CHK, S_A_SPL, S_A_RL, S_A_RR,
    S_F_WR, S_U_RL, S_U_RR, S_U_WR, S_DONE
  } state_t;

  state_t            state;
  logic [IDX_W-1:0]  b;
  logic [IDX_W-1:0]  clr;
  logic [VAL_W-1:0]  nlen, len, lv, cur_v, clen, real_p, full;
  logic [PAGE_W-1:0] start;
  logic [CNT_W-1:0]  usable, free_total;
  logic              is_free, res_ok;
  logic [PAGE_W-1:0] res_start;

  bpa_mem_req_t      mreq;
  logic [VAL_W-1:0]  rd;

  logic [K_W-1:0]    k;
  logic [VAL_W-1:0]  req_len, real0, fh;
  logic              cnt_bad;
  logic [IDX_W-1:0]  free_node, lchild, rchild, parent;
  logic [CNT_W:0]    ft_sum;

  bpa_tree_mem u_mem (.clk(clk), .req(mreq), .rdata(rd));

  // ceil log2 of the request, independent compares
  always_comb begin
    k = '0;
    for (int i = 0; i < LVL; i++) begin
      if (req.page_count > CNT_W'(1 << i)) k = k + K_W'(1);
    end
  end

  assign req_len   = VAL_W'(1) << k;
  assign cnt_bad   = (req.page_count == '0) || (req.page_count > CNT_W'(MAX_PAGES));
  assign free_node = (IDX_W'(MAX_PAGES) >> k) | (IDX_W'(req.page_index) >> k);
  assign real0     = (usable > CNT_W'(MAX_PAGES)) ? VAL_W'(MAX_PAGES) : VAL_W'(usable);
  assign fh        = full >> 1;
  assign lchild    = {b[IDX_W-2:0], 1'b0};
  assign rchild    = {b[IDX_W-2:0], 1'b1};
  assign parent    = b >> 1;
  assign ft_sum    = {1'b0, free_total} + (CNT_W+1)'(len);

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  always_comb begin
    mreq = '{we: 1'b0, addr: b, wdata: '0};
    unique case (state)
      S_CLR:   mreq = '{we: 1'b1, addr: clr, wdata: '0};
      S_BROOT: mreq = '{we: 1'b1, addr: ROOT_NODE, wdata: real0};
      S_BSTEP: mreq = '{we: (real_p != '0) && (real_p < full) && (full > VAL_W'(1)),
                        addr: lchild, wdata: (real_p > fh) ? fh : real_p};
      S_BW2:   mreq = '{we: 1'b1, addr: rchild, wdata: real_p};
      S_A_CHK: begin
        if ((len <= rd) && (len < nlen)) begin
          if (rd == nlen) mreq = '{we: 1'b1, addr: lchild, wdata: rd >> 1};
          else            mreq = '{we: 1'b0, addr: lchild, wdata: '0};
        end else if (len <= rd) begin
          mreq = '{we: 1'b1, addr: b, wdata: '0};
        end
      end
      S_A_SPL: mreq = '{we: 1'b1, addr: rchild, wdata: cur_v >> 1};
      S_A_RL:  mreq = '{we: 1'b0, addr: rchild, wdata: '0};
      S_F_WR:  mreq = '{we: 1'b1, addr: b, wdata: len};
      S_U_RL:  mreq = '{we: 1'b0, addr: {parent[IDX_W-2:0], 1'b0}, wdata: '0};
      S_U_RR:  mreq = '{we: 1'b0, addr: {parent[IDX_W-2:0], 1'b1}, wdata: '0};
      S_U_WR:  mreq = '{we: 1'b1, addr: parent,
                        wdata: (is_free && lv == clen && rd == clen) ? (lv << 1) : (lv | rd)};
      default: mreq = '{we: 1'b0, addr: b, wdata: '0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLR;
      clr        <= '0;
      usable     <= CNT_W'(MAX_PAGES);
      free_total <= CNT_W'(MAX_PAGES);
      rsp.valid  <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready && (state != S_DONE || cfg.valid)) rsp.valid <= 1'b0;
      if (cfg.valid) begin
        usable <= cfg.usable_pages;
        clr    <= '0;
        state  <= S_CLR;
      end else begin
        unique case (state)
          S_CLR: begin
            clr <= clr + IDX_W'(1);
            if (clr == IDX_W'(NODES - 1)) state <= S_BROOT;
          end
          S_BROOT: begin
            real_p     <= real0;
            full       <= VAL_W'(MAX_PAGES);
            b          <= ROOT_NODE;
            free_total <= CNT_W'(real0);
            state      <= S_BSTEP;
          end
          S_BSTEP: begin
            if ((real_p != '0) && (real_p < full) && (full > VAL_W'(1))) begin
              full <= fh;
              if (real_p > fh) begin
                real_p <= real_p - fh;
                state  <= S_BW2;
              end else begin
                b <= lchild;
              end
            end else begin
              state <= S_IDLE;
            end
          end
          S_BW2: begin
            b     <= rchild;
            state <= S_BSTEP;
          end
          S_IDLE: begin
            if (req.valid) begin
              len       <= req_len;
              res_start <= '0;
              if (req.command == CMD_ALLOC) begin
                res_ok <= 1'b0;
                b      <= ROOT_NODE;
                nlen   <= VAL_W'(MAX_PAGES);
                start  <= '0;
                state  <= cnt_bad ? S_DONE : S_A_RD;
              end else begin
                res_ok <= 1'b1;
                b      <= free_node;
                clen   <= req_len;
                state  <= cnt_bad ? S_DONE : S_F_WR;
              end
            end
          end
          S_A_RD: state <= S_A_CHK;
          S_A_CHK: begin
            cur_v <= rd;
            if ((len <= rd) && (len < nlen)) begin
              state <= (rd == nlen) ? S_A_SPL : S_A_RL;
            end else if (len > rd) begin
              state <= S_DONE;
            end else begin
              res_ok     <= 1'b1;
              res_start  <= start;
              free_total <= (free_total >= CNT_W'(len)) ? free_total - CNT_W'(len) : '0;
              is_free    <= 1'b0;
              state      <= (b == ROOT_NODE) ? S_DONE : S_U_RL;
            end
          end
          S_A_SPL: begin
            b     <= lchild;
            nlen  <= nlen >> 1;
            state <= S_A_RD;
          end
          S_A_RL: begin
            lv    <= rd;
            state <= S_A_RR;
          end
          S_A_RR: begin
            nlen  <= nlen >> 1;
            state <= S_A_RD;
            priority if ((len & lv) != '0) begin
              b <= lchild;
            end else if ((len & rd) != '0) begin
              b     <= rchild;
              start <= start + PAGE_W'(nlen >> 1);
            end else if (len <= lv) begin
              b <= lchild;
            end else if (len <= rd) begin
              b     <= rchild;
              start <= start + PAGE_W'(nlen >> 1);
            end else begin
              state <= S_DONE;
            end
          end
          S_F_WR: begin
            free_total <= (ft_sum > (CNT_W+1)'(MAX_PAGES)) ? CNT_W'(MAX_PAGES)
                                                           : CNT_W'(ft_sum);
            is_free    <= 1'b1;
            state      <= (b == ROOT_NODE) ? S_DONE : S_U_RL;
          end
          S_U_RL: state <= S_U_RR;
          S_U_RR: begin
            lv    <= rd;
            state <= S_U_WR;
          end
          S_U_WR: begin
            b     <= parent;
            clen  <= clen << 1;
            state <= (parent == ROOT_NODE) ? S_DONE : S_U_RL;
          end
          S_DONE: begin
            if (!rsp.valid || rsp.ready) begin
              rsp.valid       <= 1'b1;
              rsp.ok          <= res_ok;
              rsp.block_start <= res_start;
              rsp.free_count  <= free_total;
              state           <= S_IDLE;
            end
          end
          default: state <= S_CLR;
        endcase
      end
    end
  end

  // no item taken right after reset; clearing pass comes first
  a_rst_busy: assert property (@(posedge clk) rst |=> !req.ready)
    else $error("ready right after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("second item taken while busy");

  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    free_total <= CNT_W'(MAX_PAGES))
    else $error("free count above page space");

  a_no_node0: assert property (@(posedge clk) disable iff (rst)
    mreq.we && state != S_CLR |-> mreq.addr != '0)
    else $error("write to unused node 0");

  a_root_stop: assert property (@(posedge clk) disable iff (rst)
    state == S_U_RL |-> b != ROOT_NODE)
    else $error("upward walk past root");

endmodule

// ----- design/bpa_tree_mem.sv -----
// ----------------------------------------------------------------------------
// bpa_tree_mem
// Single-port size tree storage, registered read.
// ----------------------------------------------------------------------------
module bpa_tree_mem import bpa_pkg::*; (
  input  logic               clk,
  input  bpa_mem_req_t       req,
  output logic [VAL_W-1:0]   rdata
);

  logic [VAL_W-1:0] mem [NODES];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    rdata <= mem[req.addr];
  end

endmodule
